FILE: rtl/sjb_pkg.sv
// Package with the shared types and constants of the snapshot jitter buffer.
`default_nettype none
package sjb_pkg;

  localparam int TIME_W  = 32;
  localparam int TICK_W  = 32;
  localparam int DELAY_W = 20;
  localparam int RGAP_W  = 16;
  localparam int MINI_W  = 10;
  localparam int CFG_W   = 20;
  localparam int SLOT_W  = 4;
  localparam int BLEND_W = 17;
  localparam int FRAC_W  = 16;

  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  localparam logic [1:0] CFG_INTERP_DELAY = 2'd0;
  localparam logic [1:0] CFG_DROP_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_MIN_INTERVAL = 2'd2;

  localparam logic [1:0] MODE_EMPTY  = 2'd0;
  localparam logic [1:0] MODE_NEWEST = 2'd1;
  localparam logic [1:0] MODE_PAIR   = 2'd2;
  localparam logic [1:0] MODE_HOLD   = 2'd3;

  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;

  localparam logic [DELAY_W-1:0] INTERP_DELAY_RST = 20'd100000;
  localparam logic [RGAP_W-1:0]  DROP_LIMIT_RST   = 16'd600;
  localparam logic [MINI_W-1:0]  MIN_INTERVAL_RST = 10'd1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [BLEND_W-1:0] blend;
    logic [SLOT_W-1:0]  newer_slot;
    logic [SLOT_W-1:0]  older_slot;
    logic [1:0]         pair_mode;
    logic [SLOT_W-1:0]  write_slot;
    logic               flushed;
    logic               accepted;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/snapshot_jitter_buffer.sv
// Snapshot jitter buffer: ring of arrival times with pair search and blend divider.
// Arrive, reinitialize and short queries go to S_OUT; it loads the output register when free.
// A query walks the ring RAM one entry per S_RD/S_CHK pass (one read port, registered read),
// then, if the pair needs a blend, a restoring divider forms the 16-bit fraction.
// A new beat is taken in the cycle after the previous result has moved to the output register.
// Reset clears control state and restores the register defaults; the ring RAM is not cleared.
`default_nettype none
module snapshot_jitter_buffer
  import sjb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [63:0]       in_tdata,   // tick[31:0], now[63:32]
  input  wire logic [1:0]        in_tuser,   // op[1:0]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // accepted[0], flushed[1], write_slot[5:2], pair_mode[7:6], older_slot[11:8],
  // newer_slot[15:12], blend[32:16], zero[39:33]
  output logic [39:0]            out_tdata
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_DEPTH);

  function automatic logic [IDX_W-1:0] dec_slot(input logic [IDX_W-1:0] s);
    logic [IDX_W-1:0] r;
    if (s == '0) r = LAST_IDX;
    else         r = s - 1'b1;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] s);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, s};
    return ext[SLOT_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [RGAP_W-1:0]  rgap_r, rgap_nxt;
  logic [MINI_W-1:0]  mini_r, mini_nxt;

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [TICK_W-1:0]  newest_tick_r, newest_tick_nxt;
  logic               first_r, first_nxt;

  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               walk_first_r, walk_first_nxt;
  logic [IDX_W-1:0]   nslot_r, nslot_nxt;
  logic [TIME_W-1:0]  tn_r, tn_nxt;
  logic signed [TIME_W:0] render_r, render_nxt;
  logic [TIME_W-1:0]  rem_r, rem_nxt;
  logic [TIME_W-1:0]  gap_r, gap_nxt;
  logic [FRAC_W-1:0]  quo_r, quo_nxt;
  logic [3:0]         step_r, step_nxt;

  result_t            res_r, res_nxt;
  result_t            out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [TIME_W-1:0]  ram_wdata;
  logic [TIME_W-1:0]  ram_rdata;

  logic [1:0]         in_op;
  logic [TICK_W-1:0]  in_tick;
  logic [TIME_W-1:0]  in_now;

  logic               do_flush;
  logic               do_store;
  logic [IDX_W-1:0]   st_slot;
  logic [CNT_W-1:0]   st_fill;
  logic [TICK_W-1:0]  tick_diff;
  logic signed [TIME_W:0] to_s;
  logic signed [TIME_W:0] gap_s;
  logic signed [TIME_W:0] num_s;
  logic [TIME_W:0]    rem2;

  assign in_op   = in_tuser;
  assign in_tick = in_tdata[31:0];
  assign in_now  = in_tdata[63:32];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r};

  sjb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    delay_nxt = delay_r;
    rgap_nxt  = rgap_r;
    mini_nxt  = mini_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_INTERP_DELAY: delay_nxt = cfg_wdata;
        CFG_DROP_LIMIT:   rgap_nxt  = cfg_wdata[RGAP_W-1:0];
        CFG_MIN_INTERVAL: mini_nxt  = cfg_wdata[MINI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_diff = newest_tick_r - in_tick;
    do_flush  = 1'b0;
    do_store  = 1'b1;
    if (first_r) begin
      do_flush = 1'b1;
    end else if (fill_r != '0 && in_tick <= newest_tick_r) begin
      if (tick_diff <= {{(TICK_W-RGAP_W){1'b0}}, rgap_r}) begin
        do_store = 1'b0;
      end else begin
        do_flush = 1'b1;
      end
    end
    st_slot = do_flush ? '0 : head_r;
    st_fill = do_flush ? '0 : fill_r;
  end

  always_comb begin
    to_s  = $signed({1'b0, ram_rdata});
    gap_s = $signed({1'b0, tn_r}) - to_s;
    num_s = render_r - to_s;
    rem2  = {rem_r, 1'b0};
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    newest_tick_nxt = newest_tick_r;
    first_nxt       = first_r;
    ptr_nxt         = ptr_r;
    idx_nxt         = idx_r;
    walk_first_nxt  = walk_first_r;
    nslot_nxt       = nslot_r;
    tn_nxt          = tn_r;
    render_nxt      = render_r;
    rem_nxt         = rem_r;
    gap_nxt         = gap_r;
    quo_nxt         = quo_r;
    step_nxt        = step_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r;
    ram_we          = 1'b0;
    ram_waddr       = st_slot;
    ram_wdata       = in_now;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
          unique case (in_op)
            OP_ARRIVE: begin
              if (do_store) begin
                first_nxt          = 1'b0;
                ram_we             = 1'b1;
                head_nxt           = (st_slot == LAST_IDX) ? '0 : st_slot + 1'b1;
                fill_nxt           = (st_fill == FULL_CNT) ? FULL_CNT : st_fill + 1'b1;
                newest_tick_nxt    = in_tick;
                res_nxt.accepted   = 1'b1;
                res_nxt.flushed    = do_flush;
                res_nxt.write_slot = to_slot(st_slot);
              end
            end
            OP_QUERY: begin
              if (fill_r == CNT_W'(1)) begin
                res_nxt.pair_mode  = MODE_NEWEST;
                res_nxt.older_slot = to_slot(dec_slot(head_r));
                res_nxt.newer_slot = to_slot(dec_slot(head_r));
                res_nxt.blend      = BLEND_ONE;
              end else if (fill_r != '0) begin
                ptr_nxt        = dec_slot(head_r);
                idx_nxt        = '0;
                walk_first_nxt = 1'b1;
                render_nxt     = $signed({1'b0, in_now}) -
                                 $signed({{(TIME_W-DELAY_W+1){1'b0}}, delay_r});
                state_nxt      = S_RD;
              end
            end
            OP_REINIT: begin
              head_nxt  = '0;
              fill_nxt  = '0;
              first_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (walk_first_r) begin
          walk_first_nxt = 1'b0;
          tn_nxt         = ram_rdata;
          nslot_nxt      = ptr_r;
          ptr_nxt        = dec_slot(ptr_r);
          idx_nxt        = idx_r + 1'b1;
          state_nxt      = S_RD;
        end else if (render_r >= to_s) begin
          res_nxt.pair_mode  = MODE_PAIR;
          res_nxt.older_slot = to_slot(ptr_r);
          res_nxt.newer_slot = to_slot(nslot_r);
          if (gap_s <= $signed({{(TIME_W-MINI_W+1){1'b0}}, mini_r}) || num_s >= gap_s) begin
            res_nxt.blend = BLEND_ONE;
            state_nxt     = S_OUT;
          end else begin
            gap_nxt   = gap_s[TIME_W-1:0];
            rem_nxt   = num_s[TIME_W-1:0];
            quo_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_DIV;
          end
        end else if (idx_r == fill_r - 1'b1) begin
          res_nxt.pair_mode  = MODE_HOLD;
          res_nxt.older_slot = to_slot(ptr_r);
          res_nxt.newer_slot = to_slot(ptr_r);
          res_nxt.blend      = '0;
          state_nxt          = S_OUT;
        end else begin
          tn_nxt    = ram_rdata;
          nslot_nxt = ptr_r;
          ptr_nxt   = dec_slot(ptr_r);
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DIV: begin
        if (rem2 >= {1'b0, gap_r}) begin
          rem_nxt = TIME_W'(rem2 - {1'b0, gap_r});
          quo_nxt = {quo_r[FRAC_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[TIME_W-1:0];
          quo_nxt = {quo_r[FRAC_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 4'hF) begin
          res_nxt.blend = {1'b0, quo_nxt};
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      delay_r       <= INTERP_DELAY_RST;
      rgap_r        <= DROP_LIMIT_RST;
      mini_r        <= MIN_INTERVAL_RST;
      head_r        <= '0;
      fill_r        <= '0;
      newest_tick_r <= '0;
      first_r       <= 1'b1;
      out_valid_r   <= 1'b0;
      walk_first_r  <= 1'b0;
      idx_r         <= '0;
      step_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      delay_r       <= delay_nxt;
      rgap_r        <= rgap_nxt;
      mini_r        <= mini_nxt;
      head_r        <= head_nxt;
      fill_r        <= fill_nxt;
      newest_tick_r <= newest_tick_nxt;
      first_r       <= first_nxt;
      out_valid_r   <= out_valid_nxt;
      walk_first_r  <= walk_first_nxt;
      idx_r         <= idx_nxt;
      step_r        <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    nslot_r  <= nslot_nxt;
    tn_r     <= tn_nxt;
    render_r <= render_nxt;
    rem_r    <= rem_nxt;
    gap_r    <= gap_nxt;
    quo_r    <= quo_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/sjb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sjb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
